>>> src/rmst_pkg.sv
package rmst_pkg;

  localparam int LEAF_COUNT_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] EMPTY_MIN = 32'sh7FFF_FFFF;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        last_index;
    logic signed [VAL_W-1:0] leaf_value;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] minimum;
    logic                    in_range;
  } result_t;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_WR_LEAF,
    OP_RD_SIB,
    OP_WR_PARENT,
    OP_RD_LN,
    OP_RD_RN,
    OP_ACC_LN,
    OP_ACC_RN,
    OP_ACC_FIN,
    OP_CLIMB,
    OP_PUBLISH
  } op_t;

  // datapath status to the controller
  typedef struct packed {
    logic clr_last;
    logic mode;
    logic first_ok;
    logic last_ok;
    logic ln_lt_rn;
    logic ln_eq_rn;
    logic ln_even;
    logic rn_odd;
    logic ln_zero;
    logic rn_zero;
  } status_t;

  function automatic logic signed [VAL_W-1:0] smin(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    smin = (a < b) ? a : b;
  endfunction

endpackage

>>> src/range_minimum_segment_tree.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------
// item      | item_valid / item_ready    | item (mode, indices, leaf value)
// result    | result_valid / result_ready| result (minimum, in_range)
// config    | count_we                   | count_data (element count)
//
// an update works once per tree level from the leaf up, and a query once
// per level climbed and then finishes; either ends early when an index is
// rejected; the single tree memory port, one access per cycle with
// registered read data, paces both
// after reset all 2*BASE-1 tree nodes (2047 at 1024
// leaves) are swept to zero with item_ready low; count_we is taken throughout
// a finished result sits in the output register; the next item is taken
// while it waits, and a later query holds until that word has left
module range_minimum_segment_tree #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  rmst_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output rmst_pkg::result_t          result,
  input  logic                       count_we,
  input  logic [rmst_pkg::CNT_W-1:0] count_data
);
  import rmst_pkg::*;

  // command and status between sequencer and datapath
  op_t     op;
  status_t status;

  // sequencer: clearing sweep, update climb, two-ended query walk
  rmst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .status       (status),
    .op           (op),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // tree memory, node pointers, running minimum and output register
  rmst_datapath #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .status     (status),
    .item       (item),
    .result     (result),
    .count_we   (count_we),
    .count_data (count_data)
  );

endmodule

>>> src/rmst_datapath.sv
module rmst_datapath #(
  parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rmst_pkg::op_t                       op,
  output rmst_pkg::status_t                   status,
  input  rmst_pkg::item_t                     item,
  output rmst_pkg::result_t                   result,
  input  logic                                count_we,
  input  logic [rmst_pkg::CNT_W-1:0]          count_data
);
  import rmst_pkg::*;

  localparam int BASE   = 1 << $clog2(LEAF_COUNT);
  localparam int NODE_W = $clog2(BASE) + 1;
  localparam int DEPTH  = 2 * BASE - 1;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata;

  logic [CNT_W-1:0]        element_count;
  logic [NODE_W-1:0]       clr_addr;
  item_t                   word;
  logic [NODE_W-1:0]       ln;
  logic [NODE_W-1:0]       rn;
  logic signed [VAL_W-1:0] cur;
  logic signed [VAL_W-1:0] acc;

  logic [NODE_W-1:0]       addr;
  logic                    we;
  logic                    re;
  logic signed [VAL_W-1:0] wdata;
  logic [NODE_W-1:0]       ln_parent;
  logic [NODE_W-1:0]       rn_parent;
  logic [NODE_W-1:0]       ln_sib;
  logic [NODE_W-1:0]       first_node;
  logic [NODE_W-1:0]       last_node;
  logic                    first_ok;
  logic                    last_ok;

  assign ln_parent  = (ln - NODE_W'(1)) >> 1;
  assign rn_parent  = (rn - NODE_W'(1)) >> 1;
  assign ln_sib     = ln[0] ? ln + NODE_W'(1) : ln - NODE_W'(1);
  assign first_node = NODE_W'(BASE - 1) + NODE_W'(item.first_index);
  assign last_node  = NODE_W'(BASE - 1) + NODE_W'(item.last_index);

  assign first_ok = (CNT_W'(word.first_index) < element_count) &&
                    (32'(word.first_index) < 32'(BASE));
  assign last_ok  = (CNT_W'(word.last_index) < element_count) &&
                    (32'(word.last_index) < 32'(BASE));

  assign status.clr_last = (clr_addr == NODE_W'(DEPTH - 1));
  assign status.mode     = word.mode;
  assign status.first_ok = first_ok;
  assign status.last_ok  = last_ok;
  assign status.ln_lt_rn = (ln < rn);
  assign status.ln_eq_rn = (ln == rn);
  assign status.ln_even  = ~ln[0];
  assign status.rn_odd   = rn[0];
  assign status.ln_zero  = (ln == '0);
  assign status.rn_zero  = (rn == '0);

  // single memory port
  always_comb begin
    addr  = ln;
    we    = 1'b0;
    re    = 1'b0;
    wdata = '0;
    case (op)
      OP_CLEAR: begin
        addr = clr_addr;
        we   = 1'b1;
      end
      OP_WR_LEAF: begin
        we    = 1'b1;
        wdata = cur;
      end
      OP_RD_SIB: begin
        addr = ln_sib;
        re   = 1'b1;
      end
      OP_WR_PARENT: begin
        addr  = ln_parent;
        we    = 1'b1;
        wdata = smin(cur, rdata);
      end
      OP_RD_LN: re = 1'b1;
      OP_RD_RN: begin
        addr = rn;
        re   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CNT_RESET;
      clr_addr      <= '0;
    end else begin
      if (count_we) begin
        element_count <= count_data;
      end
      if (op == OP_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        word <= item;
        ln   <= first_node;
        rn   <= last_node;
        cur  <= item.leaf_value;
        acc  <= EMPTY_MIN;
      end
      OP_WR_PARENT: begin
        cur <= smin(cur, rdata);
        ln  <= ln_parent;
      end
      OP_ACC_LN: begin
        acc <= smin(acc, rdata);
        ln  <= ln + NODE_W'(1);
      end
      OP_ACC_RN: begin
        acc <= smin(acc, rdata);
        rn  <= rn - NODE_W'(1);
      end
      OP_ACC_FIN: acc <= smin(acc, rdata);
      OP_CLIMB: begin
        ln <= ln_parent;
        rn <= rn_parent;
      end
      OP_PUBLISH: begin
        result.minimum  <= acc;
        result.in_range <= first_ok && last_ok;
      end
      default: ;
    endcase
  end

endmodule

>>> src/rmst_ctrl.sv
module rmst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rmst_pkg::status_t status,
  output rmst_pkg::op_t     op,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready
);
  import rmst_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WR_LEAF,
    S_U_TEST,
    S_U_WR,
    S_Q_TEST,
    S_Q_ACCL,
    S_Q_RTEST,
    S_Q_ACCR,
    S_Q_BRK,
    S_Q_FIN,
    S_Q_ACCF,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   publish;

  assign item_ready = (state == S_IDLE);
  assign publish    = (state == S_OUT) && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) begin
          op         = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.mode == MODE_UPDATE) begin
          state_next = status.first_ok ? S_WR_LEAF : S_IDLE;
        end else begin
          state_next = (status.first_ok && status.last_ok) ? S_Q_TEST : S_OUT;
        end
      end
      S_WR_LEAF: begin
        op         = OP_WR_LEAF;
        state_next = S_U_TEST;
      end
      S_U_TEST: begin
        if (status.ln_zero) begin
          state_next = S_IDLE;
        end else begin
          op         = OP_RD_SIB;
          state_next = S_U_WR;
        end
      end
      S_U_WR: begin
        op         = OP_WR_PARENT;
        state_next = S_U_TEST;
      end
      S_Q_TEST: begin
        if (!status.ln_lt_rn) begin
          state_next = S_Q_FIN;
        end else if (status.ln_even) begin
          op         = OP_RD_LN;
          state_next = S_Q_ACCL;
        end else begin
          state_next = S_Q_RTEST;
        end
      end
      S_Q_ACCL: begin
        op         = OP_ACC_LN;
        state_next = S_Q_RTEST;
      end
      S_Q_RTEST: begin
        if (status.rn_odd) begin
          op         = OP_RD_RN;
          state_next = S_Q_ACCR;
        end else begin
          state_next = S_Q_BRK;
        end
      end
      S_Q_ACCR: begin
        op         = OP_ACC_RN;
        state_next = S_Q_BRK;
      end
      S_Q_BRK: begin
        if (status.ln_zero || status.rn_zero) begin
          state_next = S_Q_FIN;
        end else begin
          op         = OP_CLIMB;
          state_next = S_Q_TEST;
        end
      end
      S_Q_FIN: begin
        if (status.ln_eq_rn) begin
          op         = OP_RD_LN;
          state_next = S_Q_ACCF;
        end else begin
          state_next = S_OUT;
        end
      end
      S_Q_ACCF: begin
        op         = OP_ACC_FIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (publish) begin
          op         = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (publish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/rmst_checker.sv
module rmst_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input rmst_pkg::result_t result
);
  import rmst_pkg::*;

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // the clearing sweep follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !item_ready)
    else $error("item taken during clearing sweep");

  // one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second item taken at once");

  // a rejected query reports the empty minimum
  a_reject_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.in_range |-> result.minimum == EMPTY_MIN)
    else $error("rejected query with a real minimum");

endmodule

bind range_minimum_segment_tree rmst_checker u_rmst_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
